// File: design/hbe_pkg.sv
`timescale 1ns / 1ps

package hbe_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned DataW       = 57;
  localparam int unsigned LenW        = 6;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned NW          = LenW + 1;
  localparam int unsigned MaxDataBits = 57;

  localparam logic [LenW-1:0] BlockBitsReset = LenW'(8);

  // Codeword length n = k + r for the least r with 2^r >= k + r + 1.
  function automatic logic [NW-1:0] calc_n(input logic [LenW-1:0] k);
    int unsigned r_cnt;
    r_cnt = 0;
    for (int unsigned r = 0; r < NW; r++) begin
      if ((32'd1 << r) < (32'(k) + r + 32'd1)) begin
        r_cnt = r + 1;
      end
    end
    return NW'(32'(k) + r_cnt);
  endfunction

endpackage

// File: design/hbe_in_if.sv
`timescale 1ns / 1ps

interface hbe_in_if
  import hbe_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [DataW-1:0] data;
  logic [LenW-1:0]  short_len;

  modport source (output valid, output data, output short_len, input ready);
  modport sink   (input valid, input data, input short_len, output ready);
endinterface

// File: design/hbe_out_if.sv
`timescale 1ns / 1ps

interface hbe_out_if
  import hbe_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] code_byte;
  logic             last;

  modport source (output valid, output code_byte, output last, input ready);
  modport sink   (input valid, input code_byte, input last, output ready);
endinterface

// File: design/hbe_encoder.sv
`timescale 1ns / 1ps

module hbe_encoder
  import hbe_pkg::*;
#(
  parameter int unsigned MAX_DATA_BITS = MaxDataBits,
  parameter int unsigned CODE_W        = 7,
  parameter int unsigned IDX_W         = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [MAX_DATA_BITS-1:0] data_i,
  input  logic [LenW-1:0]          k_i,
  output logic                     enc_valid_o,
  input  logic                     enc_ready_i,
  output logic [CODE_W-1:0]        code_o,
  output logic [IDX_W-1:0]         last_idx_o
);

  localparam int unsigned ParW = CODE_W - MAX_DATA_BITS;

  logic                     valid_q;
  logic [MAX_DATA_BITS-1:0] data_q;
  logic [LenW-1:0]          k_q;
  logic [MAX_DATA_BITS-1:0] data_m;
  logic [CODE_W-1:0]        spread;
  logic [NW-1:0]            n;
  logic [NW-1:0]            n_m1;
  logic                     n_zero;

  assign n      = calc_n(k_q);
  assign n_zero = (n == '0);
  assign n_m1   = n - NW'(1);

  // A zero-length block produces no bytes: drop it here.
  assign enc_valid_o = valid_q && !n_zero;
  assign in_ready_o  = !valid_q || n_zero || enc_ready_i;
  assign last_idx_o  = IDX_W'(n_m1 >> 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_i;
      k_q    <= k_i;
    end
  end

  for (genvar i = 0; i < MAX_DATA_BITS; i++) begin : g_mask
    assign data_m[i] = data_q[i] & (NW'(i) < NW'(k_q));
  end

  // Data bit order fills the positions that are not powers of two.
  for (genvar pos = 1; pos <= CODE_W; pos++) begin : g_spread
    if ((pos & (pos - 1)) == 0) begin : g_par
      assign spread[pos-1] = 1'b0;
    end else begin : g_dat
      assign spread[pos-1] = data_m[pos - 1 - $clog2(pos + 1)];
    end
  end

  always_comb begin
    logic par;
    code_o = spread;
    for (int unsigned b = 0; b < ParW; b++) begin
      par = 1'b0;
      for (int unsigned q = 1; q <= CODE_W; q++) begin
        if (((q >> b) & 1) == 1) begin
          par = par ^ spread[q-1];
        end
      end
      code_o[(1 << b) - 1] = par;
    end
  end

endmodule

// File: design/hbe_serializer.sv
`timescale 1ns / 1ps

module hbe_serializer
  import hbe_pkg::*;
#(
  parameter int unsigned CODE_W = 7,
  parameter int unsigned BYTES  = 1,
  parameter int unsigned IDX_W  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              enc_valid_i,
  output logic              enc_ready_o,
  input  logic [CODE_W-1:0] code_i,
  input  logic [IDX_W-1:0]  last_idx_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  code_byte_o,
  output logic              last_o,
  output logic [IDX_W-1:0]  idx_o
);

  localparam int unsigned PadW = BYTES * ByteW;

  logic              busy_q;
  logic [PadW-1:0]   code_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  last_idx_q;
  logic              out_beat;

  assign out_valid_o = busy_q;
  assign last_o      = (idx_q == last_idx_q);
  assign code_byte_o = code_q[idx_q * ByteW +: ByteW];
  assign idx_o       = idx_q;
  assign out_beat    = busy_q && out_ready_i;
  assign enc_ready_o = !busy_q || (out_ready_i && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (enc_valid_i && enc_ready_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_beat) begin
      // Advance to the next byte, or drop out of busy after the last one.
      if (last_o) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc_valid_i && enc_ready_o) begin
      code_q     <= PadW'(code_i);
      last_idx_q <= last_idx_i;
    end
  end

endmodule

// File: design/hamming_block_encoder_unit.sv
`timescale 1ns / 1ps

// Hamming block encoder with variable block length.
// Input channel in_if: one beat carries a data block (data, short_len). The
// block length k is short_len, or the block_bits register when short_len is
// zero, saturated at MAX_DATA_BITS. Data bits at index k and above are ignored.
// Output channel out_if: the codeword of n = k + r bits as ceil(n/8) byte
// beats, lowest codeword position in bit 0 of the first byte, last set on the
// final byte. A block of length zero is consumed and produces no beat.
// Configuration: cfg_we_i writes cfg_data_i into block_bits (reset value 8);
// write it only while no block is in flight.
// An input beat passes the input register, then the codeword register, before
// its first byte is offered. One byte leaves per cycle while the receiver is
// ready, up to 8 bytes per block; the byte-wide output port sets this rate.
// The next block is encoded and waits while the current one drains, and is
// loaded in the cycle the last byte is taken, so bytes flow without gaps.
// When the receiver stalls the current byte holds; input ready drops once
// both the input register and the codeword register are full.
// Reset clears all valid state and sets block_bits to 8.
module hamming_block_encoder_unit
  import hbe_pkg::*;
#(
  parameter int unsigned MAX_DATA_BITS = MaxDataBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_data_i,
  hbe_in_if.sink          in_if,
  hbe_out_if.source       out_if
);

  localparam logic [LenW-1:0] MaxK   = LenW'(MAX_DATA_BITS);
  localparam int unsigned     CodeW  = int'(calc_n(MaxK));
  localparam int unsigned     Bytes  = (CodeW + ByteW - 1) / ByteW;
  localparam int unsigned     IdxW   = (Bytes > 1) ? $clog2(Bytes) : 1;

  logic [LenW-1:0]   block_bits_q;
  logic [LenW-1:0]   k_raw;
  logic [LenW-1:0]   k;
  logic              enc_valid;
  logic              enc_ready;
  logic [CodeW-1:0]  code;
  logic [IdxW-1:0]   last_idx;
  logic [IdxW-1:0]   idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bits_q <= BlockBitsReset;
    end else if (cfg_we_i) begin
      block_bits_q <= cfg_data_i;
    end
  end

  assign k_raw = (in_if.short_len != '0) ? in_if.short_len : block_bits_q;
  assign k     = (k_raw > MaxK) ? MaxK : k_raw;

  hbe_encoder #(
    .MAX_DATA_BITS (MAX_DATA_BITS),
    .CODE_W        (CodeW),
    .IDX_W         (IdxW)
  ) u_encoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .data_i      (in_if.data[MAX_DATA_BITS-1:0]),
    .k_i         (k),
    .enc_valid_o (enc_valid),
    .enc_ready_i (enc_ready),
    .code_o      (code),
    .last_idx_o  (last_idx)
  );

  hbe_serializer #(
    .CODE_W (CodeW),
    .BYTES  (Bytes),
    .IDX_W  (IdxW)
  ) u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enc_valid_i (enc_valid),
    .enc_ready_o (enc_ready),
    .code_i      (code),
    .last_idx_i  (last_idx),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .code_byte_o (out_if.code_byte),
    .last_o      (out_if.last),
    .idx_o       (idx)
  );

  // A codeword waiting in the encoder is taken as soon as the last byte goes.
  a_handover : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && out_if.last && enc_valid) |=>
      (out_if.valid && idx == '0))
    else $error("pending codeword not loaded after last byte");

  // More bytes of the same codeword follow a beat that is not the last.
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && !out_if.last) |=>
      (out_if.valid && idx == $past(idx) + IdxW'(1)))
    else $error("codeword bytes interrupted");

  // The byte index stays below the byte count of the longest codeword.
  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (32'(idx) < Bytes))
    else $error("byte index out of range");

  // An empty serializer never blocks the input side.
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with idle output");

endmodule

// File: tb/sv/tb_hamming_block_encoder_unit.sv
`timescale 1ns / 1ps

module tb_hamming_block_encoder_unit;
  import hbe_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 45;
  localparam int unsigned DrainWait  = 12;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic [LenW-1:0]  short_len;
  } block_t;

  typedef struct packed {
    logic [ByteW-1:0] code_byte;
    logic             last;
  } code_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [LenW-1:0] cfg_data_i;

  hbe_in_if  blk_if ();
  hbe_out_if cw_if ();

  hamming_block_encoder_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (blk_if),
    .out_if     (cw_if)
  );

  block_t          pending_blocks[$];
  code_beat_t      expected_beats[$];
  block_t          next_block;
  logic [LenW-1:0] block_bits_q;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     hold_left;
  int unsigned     cycle_cnt;
  int unsigned     err_cnt;
  bit              blk_taken;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Build the codeword of one block and queue its bytes.
  function automatic void predict_codeword(input logic [DataW-1:0] data,
                                           input logic [LenW-1:0] short_len);
    int          k;
    int          r;
    int          n;
    int          di;
    int          nbytes;
    logic        par;
    logic [63:0] code;
    code_beat_t  beat;
    k = (short_len != 0) ? int'(short_len) : int'(block_bits_q);
    if (k > MaxDataBits) begin
      k = MaxDataBits;
    end
    r = 0;
    while ((1 << r) < k + r + 1) begin
      r++;
    end
    n = k + r;
    if (n == 0) begin
      return;
    end
    code = '0;
    di = 0;
    for (int pos = 1; pos <= n && di < k; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        code[pos-1] = data[di];
        di++;
      end
    end
    for (int p = 1; p <= n; p = p << 1) begin
      par = 1'b0;
      for (int q = 1; q <= n; q++) begin
        if (q != p && (q & p) != 0) begin
          par ^= code[q-1];
        end
      end
      code[p-1] = par;
    end
    nbytes = (n + 7) / 8;
    for (int j = 0; j < nbytes; j++) begin
      beat.code_byte = code[8*j +: 8];
      beat.last      = (j == nbytes - 1);
      expected_beats = {expected_beats, beat};
    end
  endfunction

  task automatic queue_block(input logic [DataW-1:0] data, input logic [LenW-1:0] short_len);
    block_t b;
    b.data      = data;
    b.short_len = short_len;
    pending_blocks = {pending_blocks, b};
  endtask

  // Wait until every block is taken and every byte has left, then let the
  // pipeline settle so a zero-length block is surely gone too.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (pending_blocks.size() != 0 || blk_if.valid || expected_beats.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_block_bits(input logic [LenW-1:0] value);
    @(negedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_data_i   <= value;
    block_bits_q = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Input driver: offer the next block once the current beat is gone.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!blk_if.valid || blk_taken) begin
        blk_taken = 1'b0;
        if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_block = pending_blocks.pop_front();
          blk_if.valid     <= 1'b1;
          blk_if.data      <= next_block.data;
          blk_if.short_len <= next_block.short_len;
        end else begin
          blk_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output ready: hold low during a long stall, else stall at random.
  always @(negedge clk_i) begin
    cw_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (blk_if.valid && blk_if.ready) begin
        blk_taken = 1'b1;
        predict_codeword(blk_if.data, blk_if.short_len);
      end
      if (cw_if.valid && cw_if.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b",
                                    cw_if.code_byte, cw_if.last));
        end else begin
          code_beat_t exp_beat;
          exp_beat = expected_beats.pop_front();
          if (cw_if.code_byte !== exp_beat.code_byte) begin
            report_mismatch($sformatf("code_byte %02h, expected %02h",
                                      cw_if.code_byte, exp_beat.code_byte));
          end
          if (cw_if.last !== exp_beat.last) begin
            report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                      cw_if.last, exp_beat.last, exp_beat.code_byte));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [DataW-1:0] ones;
    logic [DataW-1:0] alt;
    logic [DataW-1:0] rnd_data;
    logic [LenW-1:0]  rnd_len;
    logic [LenW-1:0]  phase_bits[NumPhases];
    int unsigned      sel;
    phase_bits = '{6'd57, 6'd1, 6'd20, 6'd0, 6'd63, 6'd8, 6'd45, 6'd57};
    ones = '1;
    alt  = DataW'({29{2'b01}});
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    blk_if.valid     = 1'b0;
    blk_if.data      = '0;
    blk_if.short_len = '0;
    cw_if.ready      = 1'b0;
    blk_taken        = 1'b0;
    hold_left        = 0;
    cycle_cnt        = 0;
    err_cnt          = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    block_bits_q     = BlockBitsReset;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset block size, length extremes, saturation, unused bits.
    queue_block('0, 6'd0);
    queue_block(ones, 6'd0);
    queue_block(57'd1, 6'd1);
    queue_block('0, 6'd1);
    queue_block(57'd3, 6'd2);
    queue_block(57'hB, 6'd4);
    queue_block(alt, 6'd11);
    queue_block(~alt, 6'd26);
    queue_block(ones, 6'd56);
    queue_block(ones, 6'd57);
    queue_block(alt, 6'd57);
    queue_block(ones, 6'd58);
    queue_block(alt, 6'd63);
    queue_block('0, 6'd63);
    wait_idle();

    // Directed: zero length drops the block, residual lengths still work.
    write_block_bits(6'd0);
    queue_block(ones, 6'd0);
    queue_block('0, 6'd0);
    queue_block(ones, 6'd5);
    queue_block(alt, 6'd0);
    wait_idle();

    write_block_bits(6'd63);
    queue_block(ones, 6'd0);
    queue_block(~alt, 6'd0);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      write_block_bits(phase_bits[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
        end
      endcase
      // Stall the receiver for a long stretch so the block backs up.
      if (p == 4) begin
        hold_left = 400;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        sel = $urandom_range(99);
        rnd_data = DataW'({$urandom, $urandom});
        if (sel < 8) begin
          rnd_data = ones;
        end else if (sel < 16) begin
          rnd_data = '0;
        end
        sel = $urandom_range(99);
        if (sel < 35) begin
          rnd_len = '0;
        end else if (sel < 45) begin
          rnd_len = LenW'($urandom_range(57, 63));
        end else begin
          rnd_len = LenW'($urandom_range(1, 56));
        end
        queue_block(rnd_data, rnd_len);
      end
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
design/hbe_pkg.sv
design/hbe_in_if.sv
design/hbe_out_if.sv
design/hbe_encoder.sv
design/hbe_serializer.sv
design/hamming_block_encoder_unit.sv
tb/sv/tb_hamming_block_encoder_unit.sv
